[design/ssd_pkg.sv]
// Shared types, constants and the glyph decode for the seven-segment scan driver.
// Used by every module in the design folder; depends on nothing else.
package ssd_pkg;

  localparam int DIGITS    = 4;
  localparam int DIG_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int SEG_W     = 8;
  localparam int EN_W      = 4;
  localparam int NUM_W     = 2;
  localparam int FUNC_W    = 3;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 3;
  localparam int FLAG_W    = 8;

  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK      = 3'd0,
    FN_SET_CHAR  = 3'd1,
    FN_SET_POINT = 3'd2,
    FN_SET_BLINK = 3'd3,
    FN_PHASE     = 3'd4,
    FN_BLINK_ALL = 3'd5,
    FN_CLEAR     = 3'd6,
    FN_POINT_ALL = 3'd7
  } func_t;

  // One displayed digit, as it leaves the state block toward the output register.
  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  digit_enable;
    logic [NUM_W-1:0] digit_number;
  } tick_res_t;

  // ASCII to segment pattern, bit 0 is segment A. Unknown characters are blank.
  function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] ch);
    logic [SEG_W-1:0] g;
    case (ch)
      "0":      g = 8'h3F;
      "1":      g = 8'h06;
      "2":      g = 8'h5B;
      "3":      g = 8'h4F;
      "4":      g = 8'h66;
      "5":      g = 8'h6D;
      "6":      g = 8'h7D;
      "7":      g = 8'h07;
      "8":      g = 8'h7F;
      "9":      g = 8'h6F;
      "-":      g = 8'h40;
      "=":      g = 8'h48;
      "I", "i": g = 8'h06;
      "T", "t": g = 8'h78;
      "E", "e": g = 8'h79;
      "R", "r": g = 8'h50;
      "O", "o": g = 8'h5C;
      "c":      g = 8'h58;
      "N", "n": g = 8'h54;
      "D", "d": g = 8'h5E;
      "F", "f": g = 8'h71;
      "A", "a": g = 8'h77;
      "B", "b": g = 8'h7C;
      "C":      g = 8'h39;
      "u":      g = 8'h1C;
      "U":      g = 8'h3E;
      "h":      g = 8'h74;
      "H":      g = 8'h76;
      "l":      g = 8'h18;
      "L":      g = 8'h38;
      default:  g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

[design/ssd_disp_state.sv]
// Display state (patterns, point and blink flags, phase, scan index) and tick compose.
// Depends on ssd_pkg.
module ssd_disp_state
  import ssd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [FUNC_W-1:0] func,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  position,
  input  logic [FLAG_W-1:0] flag_value,
  input  logic              active_low,
  output tick_res_t         res
);

  logic [SEG_W-1:0]     pattern_r [DIGITS];
  logic [SEG_W-1:0]     pattern_nxt [DIGITS];
  logic                 point_r [DIGITS];
  logic                 point_nxt [DIGITS];
  logic                 blink_r [DIGITS];
  logic                 blink_nxt [DIGITS];
  logic                 phase_zero_r;
  logic                 phase_zero_nxt;
  logic [DIG_IDX_W-1:0] scan_r;
  logic [DIG_IDX_W-1:0] scan_nxt;

  logic                 pos_ok;
  logic [DIG_IDX_W-1:0] widx;
  logic                 flag_on;
  logic [SEG_W-1:0]     seg;
  func_t                fn;

  // Flags only ever act when the stored value is exactly one, and the phase
  // only when it is zero, so one bit of each is kept.
  assign fn      = func_t'(func);
  assign flag_on = (flag_value == FLAG_W'(1));
  assign pos_ok  = (position != '0) && (32'(position) <= DIGITS);
  assign widx    = DIG_IDX_W'(position - POS_W'(1));

  always_comb begin
    seg = pattern_r[scan_r];
    if (point_r[scan_r]) begin
      seg = seg | SEG_POINT;
    end
    if (blink_r[scan_r] && phase_zero_r) begin
      seg = SEG_BLANK;
    end
    if (active_low) begin
      seg = ~seg;
    end
    res.segments     = seg;
    res.digit_enable = EN_W'(1) << scan_r;
    res.digit_number = NUM_W'(scan_r);
  end

  always_comb begin
    pattern_nxt    = pattern_r;
    point_nxt      = point_r;
    blink_nxt      = blink_r;
    phase_zero_nxt = phase_zero_r;
    scan_nxt       = scan_r;
    if (fire) begin
      case (fn)
        FN_TICK: begin
          if (32'(scan_r) + 1 >= DIGITS) begin
            scan_nxt = '0;
          end else begin
            scan_nxt = scan_r + DIG_IDX_W'(1);
          end
        end
        FN_SET_CHAR: begin
          if (pos_ok) begin
            pattern_nxt[widx] = glyph_of(char_code);
          end
        end
        FN_SET_POINT: begin
          if (pos_ok) begin
            point_nxt[widx] = flag_on;
          end
        end
        FN_SET_BLINK: begin
          if (pos_ok) begin
            blink_nxt[widx] = flag_on;
          end
        end
        FN_PHASE: begin
          phase_zero_nxt = (flag_value == '0);
        end
        FN_BLINK_ALL: begin
          for (int i = 0; i < DIGITS; i++) begin
            blink_nxt[i] = flag_on;
          end
        end
        FN_CLEAR: begin
          for (int i = 0; i < DIGITS; i++) begin
            pattern_nxt[i] = SEG_BLANK;
            point_nxt[i]   = 1'b0;
            blink_nxt[i]   = 1'b0;
          end
        end
        FN_POINT_ALL: begin
          for (int i = 0; i < DIGITS; i++) begin
            point_nxt[i] = flag_on;
          end
        end
        default: begin
          scan_nxt = scan_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) begin
        pattern_r[i] <= SEG_BLANK;
        point_r[i]   <= 1'b0;
        blink_r[i]   <= 1'b0;
      end
      phase_zero_r <= 1'b1;
      scan_r       <= '0;
    end else begin
      pattern_r    <= pattern_nxt;
      point_r      <= point_nxt;
      blink_r      <= blink_nxt;
      phase_zero_r <= phase_zero_nxt;
      scan_r       <= scan_nxt;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_r) < DIGITS)
    else $error("scan index beyond last digit");

  a_scan_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && fn == FN_TICK) |=> $stable(scan_r))
    else $error("scan index moved without a tick");

endmodule

[design/ssd_out_reg.sv]
// Result register for the displayed digit; lets the input side run while a word waits.
// Depends on ssd_pkg.
module ssd_out_reg
  import ssd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tick_res_t        res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SEG_W-1:0] out_segments,
  output logic [EN_W-1:0]  out_digit_enable,
  output logic [NUM_W-1:0] out_digit_number
);

  logic      valid_r;
  logic      valid_nxt;
  tick_res_t data_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_segments     = data_r.segments;
  assign out_digit_enable = data_r.digit_enable;
  assign out_digit_number = data_r.digit_number;

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result register overwritten while a word waits");

endmodule

[design/seven_segment_scan_driver.sv]
// Four-digit multiplexed seven-segment scan driver: input register, state and output register.
// A tick word passes through the input register and then the output register to the out_ port.
// Throughput: one word per cycle, but a tick waits while the result register is full; host writes leave no result word.
// Reset (rst_n low, synchronous) blanks all digits, clears the flags, sets the scan to digit 0
// and the polarity to active high. Depends on ssd_pkg, ssd_disp_state and ssd_out_reg.
module seven_segment_scan_driver
  import ssd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [POS_W-1:0]  in_position,
  input  logic [FLAG_W-1:0] in_flag_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SEG_W-1:0]  out_segments,
  output logic [EN_W-1:0]   out_digit_enable,
  output logic [NUM_W-1:0]  out_digit_number,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_active_low_segments
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [FUNC_W-1:0] s1_func_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [FLAG_W-1:0] s1_flag_r;
  logic              active_low_r;
  logic              s1_is_tick;
  logic              s1_fire;
  logic              out_free;
  logic              in_fire;
  tick_res_t         res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      active_low_r <= cfg_active_low_segments;
    end
  end

  // A host write always retires; a tick retires only when the result register has room.
  assign s1_is_tick   = (func_t'(s1_func_r) == FN_TICK);
  assign s1_fire      = s1_valid_r && (!s1_is_tick || out_free);
  assign in_ready     = !s1_valid_r || s1_fire;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_func;
      s1_char_r <= in_char_code;
      s1_pos_r  <= in_position;
      s1_flag_r <= in_flag_value;
    end
  end

  ssd_disp_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .func       (s1_func_r),
    .char_code  (s1_char_r),
    .position   (s1_pos_r),
    .flag_value (s1_flag_r),
    .active_low (active_low_r),
    .res        (res)
  );

  ssd_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s1_fire && s1_is_tick),
    .res              (res),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_enable (out_digit_enable),
    .out_digit_number (out_digit_number)
  );

  a_enable_matches_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_enable == (EN_W'(1) << out_digit_number)))
    else $error("digit select does not match digit number");

  a_tick_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_is_tick && out_valid && !out_ready) |=> s1_valid_r)
    else $error("tick word dropped while result register was full");

endmodule

[sim/seven_segment_scan_driver_tb.sv]
// Testbench for the seven-segment scan driver: random and directed host words and scan ticks.
// Predicts every displayed digit and checks it; depends on ssd_pkg and the design folder.
`timescale 1ns / 100ps

module seven_segment_scan_driver_tb;
  import ssd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    func_t             func;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic [FLAG_W-1:0] flag_value;
  } host_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [FLAG_W-1:0] in_flag_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SEG_W-1:0]  out_segments;
  logic [EN_W-1:0]   out_digit_enable;
  logic [NUM_W-1:0]  out_digit_number;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_active_low_segments = 1'b0;

  seven_segment_scan_driver dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_func                 (in_func),
    .in_char_code            (in_char_code),
    .in_position             (in_position),
    .in_flag_value           (in_flag_value),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_segments            (out_segments),
    .out_digit_enable        (out_digit_enable),
    .out_digit_number        (out_digit_number),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_active_low_segments (cfg_active_low_segments)
  );

  always #5 clk = ~clk;

  host_word_t word_queue[$];
  tick_res_t  expected_digits[$];
  host_word_t next_word;
  logic       in_took = 1'b0;
  logic       steady = 1'b0;
  logic       failed = 1'b0;
  int         cycle_count = 0;
  int         cfg_writes = 0;

  // Display model.
  logic [SEG_W-1:0]  glyph_table [0:255];
  logic [SEG_W-1:0]  digit_glyph [0:3];
  logic [FLAG_W-1:0] point_flag [0:3];
  logic [FLAG_W-1:0] blink_flag [0:3];
  logic [FLAG_W-1:0] phase_value = '0;
  logic [1:0]        scan_pos = '0;
  logic              invert_segments = 1'b0;
  logic [1:0]        slot;
  logic              pos_ok;
  tick_res_t         shown;
  tick_res_t         oldest;

  function automatic host_word_t host_word(func_t f, logic [CHAR_W-1:0] ch,
                                           logic [POS_W-1:0] pos, logic [FLAG_W-1:0] val);
    host_word_t w;
    w.func = f;
    w.char_code = ch;
    w.position = pos;
    w.flag_value = val;
    return w;
  endfunction

  // Input driver: a new word goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (word_queue.size() > 0 && (steady || $urandom_range(99) >= 7)) begin
        next_word = word_queue.pop_front();
        in_valid <= 1'b1;
        in_func <= next_word.func;
        in_char_code <= next_word.char_code;
        in_position <= next_word.position;
        in_flag_value <= next_word.flag_value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 7);
  end

  // Monitor: checks displayed digits, then updates the model with accepted words.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end else begin
      in_took <= rst_n && in_valid && in_ready;
      if (rst_n) begin
        if (out_valid && out_ready) begin
          if (expected_digits.size() == 0) begin
            $error("unexpected digit word: segments %h enable %h number %h",
                   out_segments, out_digit_enable, out_digit_number);
            failed = 1'b1;
          end else begin
            oldest = expected_digits.pop_front();
            if (out_segments !== oldest.segments) begin
              $error("segments: expected %h, got %h", oldest.segments, out_segments);
              failed = 1'b1;
            end
            if (out_digit_enable !== oldest.digit_enable) begin
              $error("digit_enable: expected %h, got %h", oldest.digit_enable,
                     out_digit_enable);
              failed = 1'b1;
            end
            if (out_digit_number !== oldest.digit_number) begin
              $error("digit_number: expected %h, got %h", oldest.digit_number,
                     out_digit_number);
              failed = 1'b1;
            end
          end
        end
        if (cfg_valid && cfg_ready) begin
          invert_segments = cfg_active_low_segments;
          cfg_writes++;
        end
        if (in_valid && in_ready) begin
          // Positions count from 1; position 4 maps to slot 3 by wraparound.
          slot = in_position[1:0] - 2'd1;
          pos_ok = (in_position >= 3'd1) && (in_position <= 3'd4);
          case (func_t'(in_func))
            FN_TICK: begin
              shown.segments = digit_glyph[scan_pos];
              if (point_flag[scan_pos] == 8'd1) shown.segments = shown.segments | SEG_POINT;
              if (blink_flag[scan_pos] == 8'd1 && phase_value == 8'd0) begin
                shown.segments = SEG_BLANK;
              end
              if (invert_segments) shown.segments = ~shown.segments;
              shown.digit_enable = 4'b0001 << scan_pos;
              shown.digit_number = scan_pos;
              expected_digits.push_back(shown);
              scan_pos = scan_pos + 2'd1;
            end
            FN_SET_CHAR: if (pos_ok) digit_glyph[slot] = glyph_table[in_char_code];
            FN_SET_POINT: if (pos_ok) point_flag[slot] = in_flag_value;
            FN_SET_BLINK: if (pos_ok) blink_flag[slot] = in_flag_value;
            FN_PHASE: phase_value = in_flag_value;
            FN_BLINK_ALL: for (int i = 0; i < 4; i++) blink_flag[i] = in_flag_value;
            FN_CLEAR: begin
              for (int i = 0; i < 4; i++) begin
                digit_glyph[i] = SEG_BLANK;
                point_flag[i] = '0;
                blink_flag[i] = '0;
              end
            end
            FN_POINT_ALL: for (int i = 0; i < 4; i++) point_flag[i] = in_flag_value;
            default: ;
          endcase
        end
      end
    end
  end

  initial begin
    string      known_chars;
    host_word_t w;
    int         r;
    int         seen;

    known_chars = "0123456789-=IiTtEeRrOocNnDdFfAaBbCuUhHlL";
    for (int i = 0; i < 256; i++) glyph_table[i] = SEG_BLANK;
    glyph_table["0"] = 8'h3F; glyph_table["1"] = 8'h06; glyph_table["2"] = 8'h5B;
    glyph_table["3"] = 8'h4F; glyph_table["4"] = 8'h66; glyph_table["5"] = 8'h6D;
    glyph_table["6"] = 8'h7D; glyph_table["7"] = 8'h07; glyph_table["8"] = 8'h7F;
    glyph_table["9"] = 8'h6F; glyph_table["-"] = 8'h40; glyph_table["="] = 8'h48;
    glyph_table["I"] = 8'h06; glyph_table["i"] = 8'h06;
    glyph_table["T"] = 8'h78; glyph_table["t"] = 8'h78;
    glyph_table["E"] = 8'h79; glyph_table["e"] = 8'h79;
    glyph_table["R"] = 8'h50; glyph_table["r"] = 8'h50;
    glyph_table["O"] = 8'h5C; glyph_table["o"] = 8'h5C;
    glyph_table["N"] = 8'h54; glyph_table["n"] = 8'h54;
    glyph_table["D"] = 8'h5E; glyph_table["d"] = 8'h5E;
    glyph_table["F"] = 8'h71; glyph_table["f"] = 8'h71;
    glyph_table["A"] = 8'h77; glyph_table["a"] = 8'h77;
    glyph_table["B"] = 8'h7C; glyph_table["b"] = 8'h7C;
    glyph_table["c"] = 8'h58; glyph_table["C"] = 8'h39;
    glyph_table["u"] = 8'h1C; glyph_table["U"] = 8'h3E;
    glyph_table["h"] = 8'h74; glyph_table["H"] = 8'h76;
    glyph_table["l"] = 8'h18; glyph_table["L"] = 8'h38;
    for (int i = 0; i < 4; i++) begin
      digit_glyph[i] = SEG_BLANK;
      point_flag[i] = '0;
      blink_flag[i] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph <= 4; ph++) begin
      steady = (ph == 2);
      @(negedge clk);
      seen = cfg_writes;
      cfg_valid <= 1'b1;
      cfg_active_low_segments <= ph[0];
      while (cfg_writes == seen) @(negedge clk);
      cfg_valid <= 1'b0;

      if (ph == 0) begin
        // Character writes, including ignored positions and an unknown character.
        word_queue.push_back(host_word(FN_SET_CHAR, "8", 3'd1, 8'd0));
        word_queue.push_back(host_word(FN_SET_CHAR, "A", 3'd2, 8'd255));
        word_queue.push_back(host_word(FN_SET_CHAR, "-", 3'd3, 8'd0));
        word_queue.push_back(host_word(FN_SET_CHAR, 8'hFF, 3'd4, 8'd0));
        word_queue.push_back(host_word(FN_SET_CHAR, "1", 3'd0, 8'd0));
        word_queue.push_back(host_word(FN_SET_CHAR, "1", 3'd5, 8'd0));
        // A flag value other than 1 is stored but acts as off.
        word_queue.push_back(host_word(FN_SET_POINT, 8'd0, 3'd1, 8'd1));
        word_queue.push_back(host_word(FN_SET_POINT, 8'd0, 3'd2, 8'd2));
        word_queue.push_back(host_word(FN_SET_BLINK, 8'd0, 3'd3, 8'd1));
        word_queue.push_back(host_word(FN_SET_BLINK, 8'd0, 3'd7, 8'd1));
        word_queue.push_back(host_word(FN_PHASE, 8'd0, 3'd0, 8'd0));
        repeat (4) word_queue.push_back(host_word(FN_TICK, 8'd0, 3'd0, 8'd0));
        word_queue.push_back(host_word(FN_PHASE, 8'd0, 3'd0, 8'hFF));
        word_queue.push_back(host_word(FN_POINT_ALL, 8'd0, 3'd0, 8'd1));
        repeat (2) word_queue.push_back(host_word(FN_TICK, 8'hFF, 3'd7, 8'hFF));
        word_queue.push_back(host_word(FN_BLINK_ALL, 8'd0, 3'd0, 8'd1));
        word_queue.push_back(host_word(FN_PHASE, 8'd0, 3'd0, 8'd0));
        word_queue.push_back(host_word(FN_TICK, 8'd0, 3'd0, 8'd0));
        word_queue.push_back(host_word(FN_CLEAR, 8'd0, 3'd0, 8'd0));
        repeat (2) word_queue.push_back(host_word(FN_TICK, 8'd0, 3'd0, 8'd0));
      end else begin
        for (int n = 0; n < 460; n++) begin
          w.char_code = CHAR_W'($urandom_range(255));
          w.position = POS_W'($urandom_range(7));
          w.flag_value = FLAG_W'($urandom_range(255));
          if ($urandom_range(99) < 85) w.position = POS_W'($urandom_range(4, 1));
          if ($urandom_range(99) < 60) w.flag_value = FLAG_W'($urandom_range(1));
          r = $urandom_range(99);
          if (r < 40) begin
            w.func = FN_TICK;
          end else if (r < 65) begin
            w.func = FN_SET_CHAR;
            if ($urandom_range(99) < 75) begin
              w.char_code = known_chars.getc($urandom_range(known_chars.len() - 1));
            end
          end else if (r < 74) begin
            w.func = FN_SET_POINT;
          end else if (r < 83) begin
            w.func = FN_SET_BLINK;
          end else if (r < 89) begin
            w.func = FN_PHASE;
            if ($urandom_range(99) < 50) w.flag_value = '0;
          end else if (r < 93) begin
            w.func = FN_BLINK_ALL;
          end else if (r < 96) begin
            w.func = FN_POINT_ALL;
          end else begin
            w.func = FN_CLEAR;
          end
          word_queue.push_back(w);
        end
      end

      while (word_queue.size() != 0 || in_valid || expected_digits.size() != 0) begin
        @(posedge clk);
      end
      // Host words leave no result, so give the pipeline time to drain.
      repeat (4) @(posedge clk);
    end

    if (failed) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

endmodule
